### hw/rtl/fswp_pkg.sv
package fswp_pkg;

    // default window size
    localparam int WINDOW_DEPTH_DEF = 4;

    // field widths
    localparam int CMD_W     = 3;
    localparam int HANDLE_W  = 16;
    localparam int WORD64_W  = 64;
    localparam int ID_W      = 32;
    localparam int TICK_W    = 32;
    localparam int MIF_W     = 3;
    localparam int TMO_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OFFER      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACK        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEND       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd5;

    // offer status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESYNC   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IN_FLIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT   = 1'b1;

    localparam logic [MIF_W-1:0] MIF_RESET = 3'd2;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd1000;
    localparam logic [ID_W-1:0]  ID_FIRST  = 32'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] buffer_handle;
        logic [WORD64_W-1:0] stream_tag;
        logic [WORD64_W-1:0] timestamp_us;
        logic                key_frame;
        logic                h264;
        logic [ID_W-1:0]     frame_id;
        logic                send_ok;
    } in_item_t;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [ID_W-1:0]     out_frame_id;
        logic [HANDLE_W-1:0] out_handle;
        logic [WORD64_W-1:0] out_stream_id;
        logic [WORD64_W-1:0] out_timestamp_us;
        logic                out_key_frame;
        logic [TICK_W-1:0]   latency_ticks;
        logic                last;
    } result_t;

    // window store operations
    typedef struct packed {
        logic clear;
        logic push;
        logic shift;
        logic dec;
    } win_ctl_t;

endpackage

### hw/rtl/fswp_alu.sv
module fswp_alu
    import fswp_pkg::*;
(
    input  logic [ID_W-1:0] a,
    input  logic [ID_W-1:0] b,
    output logic            eq,
    output logic [ID_W-1:0] diff
);

    // shared id compare and tick difference
    assign eq   = (a == b);
    assign diff = a - b;

endmodule

### hw/rtl/fswp_window.sv
module fswp_window
    import fswp_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int CW = $clog2(WINDOW_DEPTH + 1),
    parameter int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  win_ctl_t          ctl,
    input  logic [IW-1:0]     rd_idx,
    input  logic [IW-1:0]     wr_idx,
    input  logic [ID_W-1:0]   push_id,
    input  logic [TICK_W-1:0] push_time,
    output logic [ID_W-1:0]   rd_id,
    output logic [TICK_W-1:0] rd_sent,
    output logic [CW-1:0]     count
);

    logic [ID_W-1:0]   ids_reg  [WINDOW_DEPTH];
    logic [TICK_W-1:0] sent_reg [WINDOW_DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign rd_id   = ids_reg[rd_idx];
    assign rd_sent = sent_reg[rd_idx];
    assign count   = count_reg;

    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries hold no reset, only slots below count are read
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            ids_reg[count_reg[IW-1:0]]  <= push_id;
            sent_reg[count_reg[IW-1:0]] <= push_time;
        end
        else if (ctl.shift)
        begin
            ids_reg[wr_idx]  <= rd_id;
            sent_reg[wr_idx] <= rd_sent;
        end
    end

endmodule

### hw/rtl/frame_send_window_pacer_top.sv
// latency: report on the cycle after the take for offer, stop, disconnect and items with no
//   window walk; a tick on a busy window adds a compare step, and on expiry a shift of each
//   later entry down; ack and failed send scan one entry per cycle, then on a hit ack takes
//   its latency and both close the gap; a new item is taken only once back in idle; a dispatch
//   strobes the cycle after its report; the single compare/subtract unit walks the window
// reset: async active low, slot and window empty, next id 1, tick count 0; no result stall
module frame_send_window_pacer_top
    import fswp_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LW = (CW > MIF_W) ? CW : MIF_W;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_LAT    = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_REPORT = 7'b0100000,
        S_DISP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // per-item context
    logic [CMD_W-1:0]    cmd_reg;
    logic [ID_W-1:0]     fid_reg;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                hit_reg, hit_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TICK_W-1:0]   latency_reg, latency_next;

    // architectural state
    logic                stopped_reg, stopped_next;
    logic                slot_valid_reg, slot_valid_next;
    logic [HANDLE_W-1:0] slot_handle_reg;
    logic [WORD64_W-1:0] slot_stream_reg;
    logic [WORD64_W-1:0] slot_time_reg;
    logic                slot_key_reg;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [TICK_W-1:0]   now_reg, now_next;
    logic [MIF_W-1:0]    mif_reg;
    logic [TMO_W-1:0]    tmo_reg;

    // window and shared unit wiring
    win_ctl_t          win_ctl;
    logic [IW-1:0]     rd_idx;
    logic [IW-1:0]     wr_idx;
    logic [ID_W-1:0]   rd_id;
    logic [TICK_W-1:0] rd_sent;
    logic [CW-1:0]     count;
    logic [ID_W-1:0]   alu_a, alu_b;
    logic              alu_eq;
    logic [ID_W-1:0]   alu_diff;

    logic              accept;
    logic              offer_load;
    logic [CW-1:0]     ptr_inc;
    logic [LW-1:0]     mif_ext;
    logic [LW-1:0]     lim;
    logic              disp_ok;
    logic [ID_W-1:0]   id_inc;

    assign accept  = start && (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE);
    assign ptr_inc = ptr_reg + 1'b1;
    assign id_inc  = next_id_reg + 1'b1;

    // offer replaces the slot unless stopped or an h264 delta meets a waiting frame
    assign offer_load = accept && (item.command == CMD_OFFER) && !stopped_reg
                        && !(slot_valid_reg && item.h264 && !item.key_frame);

    // effective in-flight limit, clamped to 1..WINDOW_DEPTH
    assign mif_ext = LW'(mif_reg);
    always_comb
    begin
        priority if (mif_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (mif_ext > LW'(WINDOW_DEPTH))
        begin
            lim = LW'(WINDOW_DEPTH);
        end
        else
        begin
            lim = mif_ext;
        end
    end

    assign disp_ok = !stopped_reg && slot_valid_reg && (LW'(count) < lim);

    fswp_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .eq   (alu_eq),
        .diff (alu_diff)
    );

    fswp_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .CW           (CW),
        .IW           (IW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .rd_idx    (rd_idx),
        .wr_idx    (wr_idx),
        .push_id   (next_id_reg),
        .push_time (now_reg),
        .rd_id     (rd_id),
        .rd_sent   (rd_sent),
        .count     (count)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        latency_next    = latency_reg;
        stopped_next    = stopped_reg;
        slot_valid_next = slot_valid_reg;
        next_id_next    = next_id_reg;
        now_next        = now_reg;
        win_ctl         = '0;
        rd_idx          = ptr_reg[IW-1:0];
        wr_idx          = ptr_reg[IW-1:0];
        alu_a           = rd_id;
        alu_b           = fid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next     = '0;
                    hit_next     = 1'b0;
                    status_next  = ST_QUEUED;
                    latency_next = '0;
                    state_next   = S_REPORT;
                    priority case (item.command)
                        CMD_OFFER:
                        begin
                            priority if (stopped_reg)
                            begin
                                status_next = ST_STOPPED;
                            end
                            else if (slot_valid_reg && item.h264 && !item.key_frame)
                            begin
                                status_next     = ST_RESYNC;
                                slot_valid_next = 1'b0;
                            end
                            else
                            begin
                                status_next     = slot_valid_reg ? ST_REPLACED : ST_QUEUED;
                                slot_valid_next = 1'b1;
                            end
                        end
                        CMD_ACK:
                        begin
                            if ((item.frame_id != '0) && (count != '0))
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                            if (count != '0)
                            begin
                                state_next = S_CHECK;
                            end
                        end
                        CMD_SEND:
                        begin
                            if (!item.send_ok && (count != '0))
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DISCONNECT:
                        begin
                            slot_valid_next = 1'b0;
                            win_ctl.clear   = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            if (!stopped_reg)
                            begin
                                stopped_next    = 1'b1;
                                slot_valid_next = 1'b0;
                                win_ctl.clear   = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one window entry compared per cycle
                if (ptr_reg < count)
                begin
                    if (alu_eq)
                    begin
                        hit_next   = 1'b1;
                        state_next = (cmd_reg == CMD_ACK) ? S_LAT : S_SHIFT;
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                    end
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_LAT:
            begin
                alu_a        = now_reg;
                alu_b        = rd_sent;
                latency_next = alu_diff;
                state_next   = S_SHIFT;
            end
            S_CHECK:
            begin
                // oldest entry expires when its age reaches the timeout
                rd_idx = '0;
                alu_a  = now_reg;
                alu_b  = rd_sent;
                if (alu_diff >= ID_W'(tmo_reg))
                begin
                    hit_next   = 1'b1;
                    ptr_next   = '0;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_SHIFT:
            begin
                // close the gap one entry per cycle
                rd_idx = ptr_inc[IW-1:0];
                if (ptr_inc < count)
                begin
                    win_ctl.shift = 1'b1;
                    ptr_next      = ptr_inc;
                end
                else
                begin
                    win_ctl.dec = 1'b1;
                    state_next  = S_REPORT;
                end
            end
            S_REPORT:
            begin
                state_next = disp_ok ? S_DISP : S_IDLE;
            end
            S_DISP:
            begin
                win_ctl.push    = 1'b1;
                slot_valid_next = 1'b0;
                next_id_next    = (id_inc == '0) ? ID_FIRST : id_inc;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            hit_reg        <= 1'b0;
            status_reg     <= ST_QUEUED;
            latency_reg    <= '0;
            stopped_reg    <= 1'b0;
            slot_valid_reg <= 1'b0;
            next_id_reg    <= ID_FIRST;
            now_reg        <= '0;
            mif_reg        <= MIF_RESET;
            tmo_reg        <= TMO_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            hit_reg        <= hit_next;
            status_reg     <= status_next;
            latency_reg    <= latency_next;
            stopped_reg    <= stopped_next;
            slot_valid_reg <= slot_valid_next;
            next_id_reg    <= next_id_next;
            now_reg        <= now_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_IN_FLIGHT: mif_reg <= cfg_wdata[MIF_W-1:0];
                    REG_ACK_TIMEOUT:   tmo_reg <= cfg_wdata[TMO_W-1:0];
                    default:           mif_reg <= mif_reg;
                endcase
            end
        end
    end

    // item payload, slot contents only matter while the slot is valid
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item.command;
            fid_reg <= item.frame_id;
        end
        if (offer_load)
        begin
            slot_handle_reg <= item.buffer_handle;
            slot_stream_reg <= item.stream_tag;
            slot_time_reg   <= item.timestamp_us;
            slot_key_reg    <= item.key_frame;
        end
    end

    // result strobe: report, then an optional dispatch in the next cycle
    assign done = (state_reg == S_REPORT) || (state_reg == S_DISP);

    always_comb
    begin
        result = '0;
        if (state_reg == S_REPORT)
        begin
            result.status        = status_reg;
            result.hit           = hit_reg;
            result.latency_ticks = latency_reg;
            result.last          = !disp_ok;
        end
        else if (state_reg == S_DISP)
        begin
            result.kind             = 1'b1;
            result.out_frame_id     = next_id_reg;
            result.out_handle       = slot_handle_reg;
            result.out_stream_id    = slot_stream_reg;
            result.out_timestamp_us = slot_time_reg;
            result.out_key_frame    = slot_key_reg;
            result.last             = 1'b1;
        end
    end

`ifndef SYNTHESIS
    // results only appear while an item is being worked on
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // a report that is not last is always followed by a dispatch
    a_disp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |=> (done && result.kind && result.last))
        else $error("missing dispatch after report");

    // window never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count <= CW'(WINDOW_DEPTH)))
        else $error("window overflow");

    // a dispatched frame never carries id zero
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind) |-> (result.out_frame_id != '0))
        else $error("dispatch with id zero");
`endif

endmodule
